// ===== rtl/char_lcd_nibble_write_sequencer_top_defines.svh =====
// assertion macros for the character lcd write sequencer
// used by char_lcd_nibble_write_sequencer_top; no other dependencies
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is held low
`define LCD_SEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also runs through reset
`define LCD_SEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LCD_SEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCD_SEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/lcd_seq_pkg.sv =====
// types, codes and the init instruction table of the character lcd sequencer
// no dependencies; imported by char_lcd_nibble_write_sequencer_top
package lcd_seq_pkg;

    localparam int DELAY_BITS = 16;
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(1000);
    localparam logic [2:0] INIT_COUNT = 3'd6;

    // bit positions in the pin level word; the nibble sits above them
    localparam int PIN_RS = 0;
    localparam int PIN_RW = 1;
    localparam int PIN_EN = 2;
    localparam int NIB_LO = 3;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_INIT = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        PH_RS_SET  = 4'd0,
        PH_HI_EN   = 4'd1,
        PH_HI_DIS  = 4'd2,
        PH_LO_EN   = 4'd3,
        PH_LO_DIS  = 4'd4,
        PH_RD_SET  = 4'd5,
        PH_BF1_EN  = 4'd6,
        PH_BF1_DIS = 4'd7,
        PH_BF2_EN  = 4'd8,
        PH_BF2_DIS = 4'd9,
        PH_EXTRA   = 4'd10,
        PH_IDLE    = 4'd15
    } t_phase;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       is_char;
    } t_in_req;

    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       en_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       refused;
    } t_out_req;

    // power-up instruction list: function set three times, display on, entry mode, clear
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h28;
            3'd3:             b = 8'h0F;
            3'd4:             b = 8'h06;
            3'd5:             b = 8'h01;
            default:          b = 8'h28;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/char_lcd_nibble_write_sequencer_top.sv =====
// character lcd 4-bit write sequencer: phase state, timing and result buffering
// depends on lcd_seq_pkg and char_lcd_nibble_write_sequencer_top_defines.svh
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------
//  in       | i_in_valid / o_in_stall      | i_in_data  (t_in_req)
//  out      | o_out_valid / i_out_stall    | o_out_data (t_out_req)
//  cfg      | i_cfg_we                     | i_cfg_wdata (delay ticks)
//
// one request per clock unless stalled: sequencer state moves when a request is taken;
// its result goes to the output register, or to the skid while that register is held.
// a two-entry output buffer (output register plus skid) sets o_in_stall; with the
// output side free the block takes a request on every cycle.
// reset clears the sequencer to idle with all pins low and delay ticks to 1000.
`include "char_lcd_nibble_write_sequencer_top_defines.svh"

module char_lcd_nibble_write_sequencer_top
    import lcd_seq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_req              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [DELAY_BITS-1:0] i_cfg_wdata
);

    logic [DELAY_BITS-1:0] r_delay;
    t_phase                r_phase, n_phase;
    logic [DELAY_BITS-1:0] r_wait, n_wait;
    logic [7:0]            r_held_byte, n_held_byte;
    logic                  r_held_is_char, n_held_is_char;
    logic [2:0]            r_init_idx, n_init_idx;
    logic                  r_in_init, n_in_init;
    logic [6:0]            r_pins, n_pins;
    logic                  n_refused;
    t_out_req              n_result;
    t_out_req              r_out, r_skid;
    logic                  r_out_valid, r_skid_valid;
    logic                  in_take, out_take;
    logic                  busy, phase_done;
    logic [DELAY_BITS-1:0] limit, wait_inc;
    logic [2:0]            idx_inc;

    // pin levels on entry to a phase
    function automatic logic [6:0] enter_pins(input t_phase p, input logic [6:0] pins,
                                              input logic [7:0] byt, input logic ch);
        logic [6:0] q;
        q = pins;
        unique case (p)
            PH_RS_SET: begin
                q[PIN_RS] = ch;
                q[PIN_RW] = 1'b0;
            end
            PH_HI_EN: begin
                q[PIN_EN]         = 1'b1;
                q[NIB_LO +: 4]    = byt[7:4];
            end
            PH_LO_EN: begin
                q[PIN_EN]         = 1'b1;
                q[NIB_LO +: 4]    = byt[3:0];
            end
            PH_RD_SET: begin
                q[PIN_RS] = 1'b0;
                q[PIN_RW] = 1'b1;
            end
            PH_BF1_EN, PH_BF2_EN: q[PIN_EN] = 1'b1;
            PH_HI_DIS, PH_LO_DIS, PH_BF1_DIS, PH_BF2_DIS: q[PIN_EN] = 1'b0;
            default: q = pins;
        endcase
        return q;
    endfunction

    // handshakes
    assign o_in_stall  = r_skid_valid;
    assign in_take     = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_take    = r_out_valid && !i_out_stall;

    // phase timing
    assign busy       = (r_phase != PH_IDLE);
    assign limit      = (r_delay == '0) ? DELAY_BITS'(1) : r_delay;
    assign wait_inc   = r_wait + DELAY_BITS'(1);
    assign phase_done = (wait_inc >= limit) || (wait_inc == '0);
    assign idx_inc    = r_init_idx + 3'd1;

    // sequencer next state for the request on the input
    always_comb begin
        n_phase        = r_phase;
        n_wait         = r_wait;
        n_held_byte    = r_held_byte;
        n_held_is_char = r_held_is_char;
        n_init_idx     = r_init_idx;
        n_in_init      = r_in_init;
        n_pins         = r_pins;
        n_refused      = 1'b0;
        case (i_in_data.cmd)
            CMD_TICK: begin
                if (busy) begin
                    n_wait = wait_inc;
                    if (phase_done) begin
                        n_wait = '0;
                        if (r_phase < PH_BF2_DIS) begin
                            n_phase = t_phase'(r_phase + 4'd1);
                            n_pins  = enter_pins(n_phase, r_pins, r_held_byte, r_held_is_char);
                        end else if (r_phase == PH_BF2_DIS && r_in_init) begin
                            n_phase = PH_EXTRA;
                        end else if (r_phase == PH_EXTRA && r_in_init) begin
                            n_init_idx = idx_inc;
                            if (idx_inc < INIT_COUNT) begin
                                n_held_byte    = init_byte(idx_inc);
                                n_held_is_char = 1'b0;
                                n_phase        = PH_RS_SET;
                                n_pins         = enter_pins(PH_RS_SET, r_pins, n_held_byte,
                                                            1'b0);
                            end else begin
                                n_in_init = 1'b0;
                                n_phase   = PH_IDLE;
                            end
                        end else begin
                            n_in_init = 1'b0;
                            n_phase   = PH_IDLE;
                        end
                    end
                end
            end
            CMD_SEND: begin
                if (busy) begin
                    n_refused = 1'b1;
                end else begin
                    n_held_byte    = i_in_data.data_byte;
                    n_held_is_char = i_in_data.is_char;
                    n_in_init      = 1'b0;
                    n_phase        = PH_RS_SET;
                    n_wait         = '0;
                    n_pins         = enter_pins(PH_RS_SET, r_pins, i_in_data.data_byte,
                                                i_in_data.is_char);
                end
            end
            CMD_INIT: begin
                if (busy) begin
                    n_refused = 1'b1;
                end else begin
                    n_in_init      = 1'b1;
                    n_init_idx     = 3'd0;
                    n_held_byte    = init_byte(3'd0);
                    n_held_is_char = 1'b0;
                    n_phase        = PH_RS_SET;
                    n_wait         = '0;
                    n_pins         = enter_pins(PH_RS_SET, r_pins, n_held_byte, 1'b0);
                end
            end
            default: n_refused = 1'b0;
        endcase
    end

    // result of this request
    always_comb begin
        n_result.rs_pin      = n_pins[PIN_RS];
        n_result.rw_pin      = n_pins[PIN_RW];
        n_result.en_pin      = n_pins[PIN_EN];
        n_result.data_nibble = n_pins[NIB_LO +: 4];
        n_result.busy_res    = (n_phase != PH_IDLE);
        n_result.refused     = n_refused;
    end

    // delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_wait         <= '0;
            r_held_byte    <= '0;
            r_held_is_char <= 1'b0;
            r_init_idx     <= '0;
            r_in_init      <= 1'b0;
            r_pins         <= '0;
        end else if (in_take) begin
            r_phase        <= n_phase;
            r_wait         <= n_wait;
            r_held_byte    <= n_held_byte;
            r_held_is_char <= n_held_is_char;
            r_init_idx     <= n_init_idx;
            r_in_init      <= n_in_init;
            r_pins         <= n_pins;
        end
    end

    // output register and skid stage, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_take;
            end
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output register and skid stage, payload
    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_take) begin
                r_out <= n_result;
            end
        end else if (in_take) begin
            r_skid <= n_result;
        end
    end

    // checks
    `LCD_SEQ_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid full with empty output register")
    `LCD_SEQ_ASSERT(a_refused_when_busy, i_clk, i_rst_n, (r_out_valid && r_out.refused) |-> r_out.busy_res, "request refused while sequencer idle")
    `LCD_SEQ_ASSERT(a_idle_not_init, i_clk, i_rst_n, (r_phase == PH_IDLE) |-> !r_in_init, "init flag set while idle")
    `LCD_SEQ_ASSERT(a_init_is_command, i_clk, i_rst_n, r_in_init |-> !r_held_is_char, "init instruction marked as character data")

endmodule
